[src/revp_pkg.sv]
// ----------------------------------------------------------------------------
// revp_pkg
// Shared widths, direction codes and configuration register indexes for the
// rotary encoder volume pulser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package revp_pkg;

  localparam int TickWidth   = 16;
  localparam int CountWidth  = 3;
  localparam int QueueWidth  = 2;
  localparam int CfgIdxWidth = 3;
  localparam int CfgDatWidth = 16;

  typedef logic [TickWidth-1:0] tick_t;

  typedef enum logic [1:0] {
    DirCw      = 2'd0,
    DirCcw     = 2'd1,
    DirUnknown = 2'd2
  } dir_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegMaxEdgeGap      = 3'd0,
    RegPulseTicks      = 3'd1,
    RegResetHoldTicks  = 3'd2,
    RegResetPulseTicks = 3'd3,
    RegDetentThreshold = 3'd4
  } cfg_reg_t;

  localparam logic [1:0] PhaseIdle    = 2'd0;
  localparam logic [1:0] PhaseHeld    = 2'd1;
  localparam logic [1:0] PhaseReset   = 2'd2;

  localparam logic [CountWidth-1:0] CountMax = '1;
  localparam logic [QueueWidth-1:0] QueueMax = '1;

  localparam tick_t      MaxEdgeGapRst      = tick_t'(250);
  localparam tick_t      PulseTicksRst      = tick_t'(18);
  localparam tick_t      ResetHoldTicksRst  = tick_t'(450);
  localparam tick_t      ResetPulseTicksRst = tick_t'(2);
  localparam logic [CountWidth-1:0] DetentThresholdRst = CountWidth'(3);

endpackage

[src/revp_if.sv]
// ----------------------------------------------------------------------------
// revp_if
// Valid/ready channels of the rotary encoder volume pulser: line samples,
// drive-line results and configuration writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface revp_sample_if;
  logic valid;
  logic ready;
  logic line_a;
  logic line_b;
  logic key_level;
  logic tick;

  modport source (output valid, line_a, line_b, key_level, tick, input ready);
  modport sink   (input valid, line_a, line_b, key_level, tick, output ready);
endinterface

interface revp_result_if;
  logic       valid;
  logic       ready;
  logic       vol_up;
  logic       vol_down;
  logic       reset_line;
  logic [1:0] turn_direction;

  modport source (output valid, vol_up, vol_down, reset_line, turn_direction, input ready);
  modport sink   (input valid, vol_up, vol_down, reset_line, turn_direction, output ready);
endinterface

interface revp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [revp_pkg::CfgIdxWidth-1:0]  index;
  logic [revp_pkg::CfgDatWidth-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/rotary_encoder_volume_pulser.sv]
// ----------------------------------------------------------------------------
// rotary_encoder_volume_pulser
// Request to result: input register, a single pass of state update, result register.
// Throughput: one sample per cycle while the result side is not stalled.
// Reset (rst, synchronous): counters cleared, direction unknown, drive lines
// up 0, down 0, reset 1, configuration back to defaults.
// Quadrature decode with detent counting, volume pulse queue and key-hold reset pulse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotary_encoder_volume_pulser (
  input  logic                 clk,
  input  logic                 rst,
  revp_sample_if.sink          sample,
  revp_result_if.source        result,
  revp_cfg_if.sink             cfg
);

  typedef struct packed {
    revp_pkg::tick_t                      tick_count;
    logic                                 primed;
    logic                                 prev_a;
    logic                                 prev_b;
    revp_pkg::dir_t                       roll_dir;
    logic [revp_pkg::CountWidth-1:0]      edge_count;
    logic [revp_pkg::QueueWidth-1:0]      queued_steps;
    logic                                 pulse_active;
    logic                                 pulse_timing;
    revp_pkg::tick_t                      pulse_start;
    revp_pkg::tick_t                      last_edge_time;
    logic [1:0]                           press_phase;
    logic                                 key_timing;
    revp_pkg::tick_t                      key_start;
    logic                                 drv_up;
    logic                                 drv_down;
    logic                                 drv_reset;
  } state_t;

  localparam state_t StateRst = '{
    tick_count:     '0,
    primed:         1'b0,
    prev_a:         1'b0,
    prev_b:         1'b0,
    roll_dir:       revp_pkg::DirUnknown,
    edge_count:     '0,
    queued_steps:   '0,
    pulse_active:   1'b0,
    pulse_timing:   1'b0,
    pulse_start:    '0,
    last_edge_time: '0,
    press_phase:    revp_pkg::PhaseIdle,
    key_timing:     1'b0,
    key_start:      '0,
    drv_up:         1'b0,
    drv_down:       1'b0,
    drv_reset:      1'b1
  };

  revp_pkg::tick_t                  max_edge_gap;
  revp_pkg::tick_t                  pulse_ticks;
  revp_pkg::tick_t                  reset_hold_ticks;
  revp_pkg::tick_t                  reset_pulse_ticks;
  logic [revp_pkg::CountWidth-1:0]  detent_threshold;

  state_t st;
  state_t st_next;

  logic s_valid;
  logic s_a;
  logic s_b;
  logic s_key;
  logic s_tick;
  logic s_advance;
  logic out_valid;

  assign cfg.ready    = 1'b1;
  assign s_advance    = s_valid && (!out_valid || result.ready);
  assign sample.ready = !s_valid || s_advance;
  assign result.valid = out_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_edge_gap      <= revp_pkg::MaxEdgeGapRst;
      pulse_ticks       <= revp_pkg::PulseTicksRst;
      reset_hold_ticks  <= revp_pkg::ResetHoldTicksRst;
      reset_pulse_ticks <= revp_pkg::ResetPulseTicksRst;
      detent_threshold  <= revp_pkg::DetentThresholdRst;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        revp_pkg::RegMaxEdgeGap:      max_edge_gap      <= cfg.data;
        revp_pkg::RegPulseTicks:      pulse_ticks       <= cfg.data;
        revp_pkg::RegResetHoldTicks:  reset_hold_ticks  <= cfg.data;
        revp_pkg::RegResetPulseTicks: reset_pulse_ticks <= cfg.data;
        revp_pkg::RegDetentThreshold:
          detent_threshold <= cfg.data[revp_pkg::CountWidth-1:0];
        default: ;
      endcase
    end
  end

  // one pass of decode, key and pulse handling
  always_comb begin
    logic                  diff_a;
    logic                  diff_b;
    logic                  edge_seen;
    revp_pkg::dir_t        edge_dir;
    revp_pkg::tick_t       gap;

    st_next   = st;
    diff_a    = s_a ^ st.prev_a;
    diff_b    = s_b ^ st.prev_b;
    edge_seen = 1'b0;
    edge_dir  = revp_pkg::DirUnknown;

    st_next.tick_count = st.tick_count + revp_pkg::tick_t'(s_tick);
    gap = st_next.tick_count - st.last_edge_time;

    if (!st.primed) begin
      st_next.primed = 1'b1;
    end else if (diff_a && !diff_b) begin
      edge_seen = 1'b1;
      edge_dir  = (s_a == s_b) ? revp_pkg::DirCcw : revp_pkg::DirCw;
    end else if (diff_b && !diff_a) begin
      edge_seen = 1'b1;
      edge_dir  = (s_a == s_b) ? revp_pkg::DirCw : revp_pkg::DirCcw;
    end

    if (edge_seen) begin
      if (edge_dir != st.roll_dir) begin
        st_next.roll_dir     = edge_dir;
        st_next.edge_count   = revp_pkg::CountWidth'(1);
        st_next.queued_steps = '0;
        st_next.pulse_timing = 1'b0;
        st_next.pulse_active = 1'b0;
        st_next.drv_up       = 1'b0;
        st_next.drv_down     = 1'b0;
      end else begin
        if (gap > max_edge_gap) begin
          st_next.edge_count = revp_pkg::CountWidth'(1);
        end else if (st.edge_count != revp_pkg::CountMax) begin
          st_next.edge_count = st.edge_count + revp_pkg::CountWidth'(1);
        end
        if (st_next.edge_count > detent_threshold) begin
          if (!st.pulse_active) begin
            st_next.pulse_active = 1'b1;
            if (edge_dir == revp_pkg::DirCw) begin
              st_next.drv_up = 1'b1;
            end else begin
              st_next.drv_down = 1'b1;
            end
            st_next.pulse_start  = st_next.tick_count;
            st_next.pulse_timing = 1'b1;
          end
          if (st.queued_steps != revp_pkg::QueueMax) begin
            st_next.queued_steps = st.queued_steps + revp_pkg::QueueWidth'(1);
          end
          st_next.edge_count = '0;
        end
      end
      st_next.last_edge_time = st_next.tick_count;
    end
    st_next.prev_a = s_a;
    st_next.prev_b = s_b;

    // key hold: issue the active-low reset pulse
    if (st.press_phase != revp_pkg::PhaseReset) begin
      if (!s_key) begin
        st_next.press_phase = revp_pkg::PhaseIdle;
        st_next.key_timing  = 1'b0;
      end else begin
        st_next.press_phase = revp_pkg::PhaseHeld;
        if (!st.key_timing) begin
          st_next.key_start  = st_next.tick_count;
          st_next.key_timing = 1'b1;
        end else if ((st_next.tick_count - st.key_start) > reset_hold_ticks) begin
          st_next.drv_reset   = 1'b0;
          st_next.press_phase = revp_pkg::PhaseReset;
          st_next.key_start   = st_next.tick_count;
        end
      end
    end else if ((st_next.tick_count - st.key_start) >= reset_pulse_ticks) begin
      st_next.drv_reset   = 1'b1;
      st_next.key_timing  = 1'b0;
      st_next.press_phase = revp_pkg::PhaseHeld;
    end

    // volume pulse: end or repeat from the queue
    if (st_next.pulse_timing &&
        ((st_next.tick_count - st_next.pulse_start) > pulse_ticks)) begin
      if (st_next.queued_steps < revp_pkg::QueueWidth'(2)) begin
        st_next.drv_up       = 1'b0;
        st_next.drv_down     = 1'b0;
        st_next.pulse_timing = 1'b0;
        st_next.queued_steps = '0;
        st_next.pulse_active = 1'b0;
      end else begin
        st_next.queued_steps = st_next.queued_steps - revp_pkg::QueueWidth'(1);
        if (st_next.roll_dir == revp_pkg::DirCw) begin
          st_next.drv_up = 1'b1;
        end else begin
          st_next.drv_down = 1'b1;
        end
        st_next.pulse_start = st_next.tick_count;
      end
    end
  end

  // input register, state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid   <= 1'b0;
      out_valid <= 1'b0;
      st        <= StateRst;
    end else begin
      if (sample.valid && sample.ready) begin
        s_valid <= 1'b1;
        s_a     <= sample.line_a;
        s_b     <= sample.line_b;
        s_key   <= sample.key_level;
        s_tick  <= sample.tick;
      end else if (s_advance) begin
        s_valid <= 1'b0;
      end

      if (s_advance) begin
        st                    <= st_next;
        out_valid             <= 1'b1;
        result.vol_up         <= st_next.drv_up;
        result.vol_down       <= st_next.drv_down;
        result.reset_line     <= st_next.drv_reset;
        result.turn_direction <= st_next.roll_dir;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[tb/rotary_encoder_volume_pulser_tb.sv]
// ----------------------------------------------------------------------------
// rotary_encoder_volume_pulser_tb
// Drives encoder line, key and tick samples into the volume pulser and checks
// every drive-line result against a cycle-free predictor of the decoder,
// detent counter, pulse queue and key-hold reset. The run covers a short
// directed sequence, register extremes, random settings with bursty samples
// and a stalling result side, and a run of idle ticks past the edge gap limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotary_encoder_volume_pulser_tb;

  localparam int              IdleLimit    = 2000;
  localparam int              RandomPhases = 8;
  localparam int              PhaseItems   = 190;
  localparam revp_pkg::tick_t TickTop      = '1;

  typedef struct packed {
    logic       up;
    logic       down;
    logic       reset_line;
    logic [1:0] dir;
  } drive_t;

  logic clk;
  logic rst;

  revp_sample_if sample();
  revp_result_if result();
  revp_cfg_if    cfg();

  rotary_encoder_volume_pulser i_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .result (result),
    .cfg    (cfg)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predicted block state
  revp_pkg::tick_t                 tick_now, pulse_t0, last_edge_t, key_t0;
  logic                            primed, prev_a, prev_b;
  revp_pkg::dir_t                  roll;
  logic [revp_pkg::CountWidth-1:0] edges;
  logic [revp_pkg::QueueWidth-1:0] queued;
  logic [1:0]                      press;
  logic                            pulse_on, pulse_timing, key_timing;
  logic                            up_drv, down_drv, reset_drv;

  // predicted configuration
  revp_pkg::tick_t                 gap_limit, pulse_len, hold_len, release_len;
  logic [revp_pkg::CountWidth-1:0] detent;

  drive_t drive_q[$];

  int          fail_count      = 0;
  int          sent_count      = 0;
  int          results_checked = 0;
  int          settings_count  = 0;
  int          vol_steps       = 0;
  int          reset_pulses    = 0;
  int          idle_cycles     = 0;
  int unsigned burst_left      = 0;
  int unsigned stall_left      = 0;
  logic [7:0]  stall_mask      = 8'hFF;

  // stimulus position
  logic        cur_a     = 1'b0;
  logic        cur_b     = 1'b0;
  logic        spin_cw   = 1'b1;
  logic        key_on    = 1'b0;
  int unsigned key_left  = 0;

  function automatic revp_pkg::tick_t ticks_since(input revp_pkg::tick_t mark);
    return revp_pkg::tick_t'(tick_now - mark);
  endfunction

  task automatic reset_predictor();
    gap_limit    = revp_pkg::MaxEdgeGapRst;
    pulse_len    = revp_pkg::PulseTicksRst;
    hold_len     = revp_pkg::ResetHoldTicksRst;
    release_len  = revp_pkg::ResetPulseTicksRst;
    detent       = revp_pkg::DetentThresholdRst;
    tick_now     = '0;
    pulse_t0     = '0;
    last_edge_t  = '0;
    key_t0       = '0;
    primed       = 1'b0;
    prev_a       = 1'b0;
    prev_b       = 1'b0;
    roll         = revp_pkg::DirUnknown;
    edges        = '0;
    queued       = '0;
    press        = revp_pkg::PhaseIdle;
    pulse_on     = 1'b0;
    pulse_timing = 1'b0;
    key_timing   = 1'b0;
    up_drv       = 1'b0;
    down_drv     = 1'b0;
    reset_drv    = 1'b1;
  endtask

  function automatic drive_t next_drive(input logic a, input logic b, input logic key,
                                        input logic tk);
    logic           moved;
    revp_pkg::dir_t dir;
    drive_t         d;
    moved = 1'b0;
    dir   = revp_pkg::DirUnknown;
    if (tk) tick_now = tick_now + 1'b1;

    // quadrature decode
    if (!primed) begin
      primed = 1'b1;
    end else if (a != prev_a && b == prev_b) begin
      dir   = (a == b) ? revp_pkg::DirCcw : revp_pkg::DirCw;
      moved = 1'b1;
    end else if (b != prev_b && a == prev_a) begin
      dir   = (a == b) ? revp_pkg::DirCw : revp_pkg::DirCcw;
      moved = 1'b1;
    end
    if (moved) begin
      if (dir != roll) begin
        roll         = dir;
        edges        = 3'd1;
        queued       = '0;
        pulse_timing = 1'b0;
        pulse_on     = 1'b0;
        up_drv       = 1'b0;
        down_drv     = 1'b0;
      end else begin
        if (ticks_since(last_edge_t) > gap_limit) edges = 3'd1;
        else if (edges < revp_pkg::CountMax) edges = edges + 1'b1;
        if (edges > detent) begin
          if (!pulse_on) begin
            pulse_on = 1'b1;
            if (dir == revp_pkg::DirCw) up_drv = 1'b1;
            else down_drv = 1'b1;
            pulse_t0     = tick_now;
            pulse_timing = 1'b1;
            vol_steps++;
            if (queued < revp_pkg::QueueMax) queued = queued + 1'b1;
          end else if (queued < revp_pkg::QueueMax) begin
            queued = queued + 1'b1;
          end
          edges = '0;
        end
      end
      last_edge_t = tick_now;
    end
    prev_a = a;
    prev_b = b;

    // key hold reset
    if (press != revp_pkg::PhaseReset) begin
      if (!key) begin
        press      = revp_pkg::PhaseIdle;
        key_timing = 1'b0;
      end else begin
        press = revp_pkg::PhaseHeld;
        if (!key_timing) begin
          key_t0     = tick_now;
          key_timing = 1'b1;
        end else if (ticks_since(key_t0) > hold_len) begin
          reset_drv = 1'b0;
          press     = revp_pkg::PhaseReset;
          key_t0    = tick_now;
          reset_pulses++;
        end
      end
    end else if (ticks_since(key_t0) >= release_len) begin
      reset_drv  = 1'b1;
      key_timing = 1'b0;
      press      = revp_pkg::PhaseHeld;
    end

    // volume pulse timing
    if (pulse_timing && ticks_since(pulse_t0) > pulse_len) begin
      if (queued < 2'd2) begin
        up_drv       = 1'b0;
        down_drv     = 1'b0;
        pulse_timing = 1'b0;
        queued       = '0;
        pulse_on     = 1'b0;
      end else begin
        queued = queued - 1'b1;
        if (roll == revp_pkg::DirCw) up_drv = 1'b1;
        else down_drv = 1'b1;
        pulse_t0 = tick_now;
        vol_steps++;
      end
    end

    d.up         = up_drv;
    d.down       = down_drv;
    d.reset_line = reset_drv;
    d.dir        = roll;
    return d;
  endfunction

  task automatic send_sample(input logic a, input logic b, input logic key, input logic tk);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk);
        sample.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    sample.valid     <= 1'b1;
    sample.line_a    <= a;
    sample.line_b    <= b;
    sample.key_level <= key;
    sample.tick      <= tk;
    do @(posedge clk); while (!sample.ready);
    drive_q.push_back(next_drive(a, b, key, tk));
    sent_count++;
    cur_a = a;
    cur_b = b;
  endtask

  task automatic send_turn(input logic cw, input logic key, input logic tk);
    if ((cur_a == cur_b) == cw) send_sample(~cur_a, cur_b, key, tk);
    else send_sample(cur_a, ~cur_b, key, tk);
  endtask

  task automatic hold_samples();
    @(negedge clk);
    sample.valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic write_reg(input revp_pkg::cfg_reg_t idx, input revp_pkg::tick_t val);
    hold_samples();
    while (drive_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      revp_pkg::RegMaxEdgeGap:      gap_limit   = val;
      revp_pkg::RegPulseTicks:      pulse_len   = val;
      revp_pkg::RegResetHoldTicks:  hold_len    = val;
      revp_pkg::RegResetPulseTicks: release_len = val;
      revp_pkg::RegDetentThreshold: detent      = val[revp_pkg::CountWidth-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_all(input revp_pkg::tick_t gap, input revp_pkg::tick_t plen,
                         input revp_pkg::tick_t hold, input revp_pkg::tick_t rlen,
                         input logic [revp_pkg::CountWidth-1:0] thr);
    write_reg(revp_pkg::RegMaxEdgeGap, gap);
    write_reg(revp_pkg::RegPulseTicks, plen);
    write_reg(revp_pkg::RegResetHoldTicks, hold);
    write_reg(revp_pkg::RegResetPulseTicks, rlen);
    write_reg(revp_pkg::RegDetentThreshold, revp_pkg::tick_t'(thr));
    settings_count++;
  endtask

  function automatic revp_pkg::tick_t pick_ticks(input int unsigned top);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return TickTop;
    return revp_pkg::tick_t'($urandom_range(0, top));
  endfunction

  // mostly clean detent turns, some holds, double-line glitches and noise
  task automatic random_stretch(input int n, input int unsigned tick_pct);
    int unsigned r;
    logic        tk;
    repeat (n) begin
      r  = $urandom_range(0, 99);
      tk = ($urandom_range(0, 99) < tick_pct);
      if (key_left == 0) begin
        key_on   = ($urandom_range(0, 2) == 0);
        key_left = $urandom_range(1, 60);
      end
      key_left--;
      if (r < 4) spin_cw = ~spin_cw;
      if (r < 75) send_turn(spin_cw, key_on, tk);
      else if (r < 85) send_sample(cur_a, cur_b, key_on, tk);
      else if (r < 92) send_sample(~cur_a, ~cur_b, key_on, tk);
      else send_sample(1'($urandom), 1'($urandom), 1'($urandom), tk);
    end
  endtask

  task automatic test_directed();
    send_sample(1'b0, 1'b0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0, 1'b1);
    repeat (4) send_turn(1'b1, 1'b0, 1'b1);
    repeat (4) send_turn(1'b1, 1'b1, 1'b0);
    send_turn(1'b0, 1'b1, 1'b1);
    repeat (4) send_turn(1'b0, 1'b0, 1'b1);
    send_sample(cur_a, cur_b, 1'b1, 1'b1);
    repeat (4) send_sample(cur_a, cur_b, 1'b0, 1'b1);
  endtask

  task automatic test_register_extremes();
    set_all('0, '0, '0, '0, 3'd1);
    random_stretch(60, 30);
    set_all('0, '0, '0, '0, 3'd1);
    random_stretch(40, 0);
    set_all(TickTop, TickTop, TickTop, TickTop, 3'd7);
    random_stretch(60, 60);
    set_all(TickTop, 16'd3, 16'd2, TickTop, 3'd6);
    random_stretch(60, 80);
  endtask

  task automatic test_random_settings();
    repeat (RandomPhases) begin
      set_all(pick_ticks(40), pick_ticks(12), pick_ticks(30), pick_ticks(6),
              3'($urandom_range(1, 7)));
      random_stretch(PhaseItems, $urandom_range(20, 100));
    end
  endtask

  task automatic test_idle_ticks();
    set_all(16'd20, 16'd4, 16'd10, 16'd2, 3'd2);
    repeat (30) send_sample(cur_a, cur_b, 1'b0, 1'b1);
    random_stretch(120, 90);
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(32, 160);
      if ($urandom_range(0, 3) == 0) stall_mask = 8'hFF;
      else stall_mask = 8'($urandom) | (8'h01 << $urandom_range(0, 7));
    end
    stall_left--;
    result.ready <= stall_mask[0];
    stall_mask = {stall_mask[0], stall_mask[7:1]};
  end

  always @(posedge clk) begin : check_results
    drive_t want;
    if (!rst && result.valid && result.ready) begin
      if (drive_q.size() == 0) begin
        $display("%0t: unexpected result: up %b down %b reset %b dir %0d", $time,
                 result.vol_up, result.vol_down, result.reset_line, result.turn_direction);
        fail_count++;
      end else begin
        want = drive_q.pop_front();
        results_checked++;
        if (result.vol_up !== want.up) begin
          $display("%0t: vol_up expected %b actual %b", $time, want.up, result.vol_up);
          fail_count++;
        end
        if (result.vol_down !== want.down) begin
          $display("%0t: vol_down expected %b actual %b", $time, want.down, result.vol_down);
          fail_count++;
        end
        if (result.reset_line !== want.reset_line) begin
          $display("%0t: reset_line expected %b actual %b", $time, want.reset_line,
                   result.reset_line);
          fail_count++;
        end
        if (result.turn_direction !== want.dir) begin
          $display("%0t: turn_direction expected %0d actual %0d", $time, want.dir,
                   result.turn_direction);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample.valid && sample.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no request accepted for %0d cycles", $time, IdleLimit);
      $display("rotary_encoder_volume_pulser_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst              = 1'b1;
    sample.valid     = 1'b0;
    sample.line_a    = 1'b0;
    sample.line_b    = 1'b0;
    sample.key_level = 1'b0;
    sample.tick      = 1'b0;
    cfg.valid        = 1'b0;
    cfg.index        = revp_pkg::RegMaxEdgeGap;
    cfg.data         = '0;
    result.ready     = 1'b0;
    reset_predictor();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_register_extremes();
    test_random_settings();
    test_idle_ticks();

    hold_samples();
    while (drive_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d samples sent, %0d results checked, %0d register settings",
             sent_count, results_checked, settings_count);
    $display("%0d volume steps and %0d reset pulses predicted, tick counter at %0d",
             vol_steps, reset_pulses, tick_now);
    if (fail_count == 0) begin
      $display("rotary_encoder_volume_pulser_tb: done, clean");
    end else begin
      $display("rotary_encoder_volume_pulser_tb: done, errors");
    end
    $finish;
  end

endmodule
